FILE: src/bla_pkg.sv
// bla_pkg: shared constants for the battery level averager.
// Field widths, fixed-point constants, status codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package bla_pkg;

    // default parameter values
    localparam int COUNT_BITS_DEF = 16;
    localparam int ADC_BITS_DEF   = 12;

    // port field widths
    localparam int NOW_W    = 32;
    localparam int CODE_W   = 12;
    localparam int STATUS_W = 2;
    localparam int PCT_W    = 14;
    localparam int MV_CFG_W = 14;
    localparam int GAIN_W   = 16;
    localparam int INT_W    = 8;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // fixed-point scaling
    localparam int MV_REF    = 3300;   // full-scale reference in mV
    localparam int FULL_PCT  = 10000;  // 100.00 percent in hundredths
    localparam int GAIN_FRAC = 8;      // gain is Q8.8
    localparam int K_W       = 28;     // width of MV_REF * gain
    localparam int MV_W      = 20;     // mean mV stays below 3300 * 256
    localparam int SCALE_W   = 28;     // (mv - low) * FULL_PCT

    // result status codes
    localparam logic [STATUS_W-1:0] ST_SAMPLING = 2'd0;
    localparam logic [STATUS_W-1:0] ST_VALID    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HIGH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd3;

endpackage

FILE: src/bla_mul.sv
// bla_mul: bit-serial shift-add multiplier, one multiplier bit per cycle.
// Standalone; used by the averager top level to form sum * 3300 * gain.
`timescale 1ns / 1ps

module bla_mul #(
    parameter int A_W = 28,
    parameter int B_W = 28
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic               o_done,
    output logic [A_W+B_W-1:0] o_prod
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(A_W + 1);

    logic [P_W-1:0]   r_acc;
    logic [B_W-1:0]   r_b;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [B_W:0]     w_sum;

    // add multiplicand into the upper half when the current bit is set
    always_comb begin
        w_sum = {1'b0, r_acc[P_W-1:A_W]} + (r_acc[0] ? {1'b0, r_b} : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(A_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= {{B_W{1'b0}}, i_a};
            r_b   <= i_b;
        end else if (r_busy) begin
            r_acc <= {w_sum, r_acc[A_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

FILE: src/bla_div.sv
// bla_div: bit-serial restoring divider, one quotient bit per cycle.
// Standalone; shared by both divisions of a report in the averager top level.
`timescale 1ns / 1ps

module bla_div #(
    parameter int N_W = 56,
    parameter int D_W = 36
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [N_W-1:0]           i_dvd,    // left-aligned dividend
    input  logic [D_W-1:0]           i_dvs,
    input  logic [$clog2(N_W+1)-1:0] i_iters,  // quotient bits to produce
    output logic                     o_done,
    output logic [N_W-1:0]           o_quo     // quotient in the low i_iters bits
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   r_q;
    logic [D_W-1:0]   r_rem;
    logic [D_W-1:0]   r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [D_W:0] w_shift;
    logic [D_W:0] w_diff;
    logic         w_ge;

    always_comb begin
        w_shift = {r_rem, r_q[N_W-1]};
        w_diff  = w_shift - {1'b0, r_dvs};
        w_ge    = !w_diff[D_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_iters;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dvd;
            r_rem <= '0;
            r_dvs <= i_dvs;
        end else if (r_busy) begin
            r_q   <= {r_q[N_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[D_W-1:0] : w_shift[D_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

FILE: src/battery_level_averager_unit.sv
// battery_level_averager_unit: averages ADC battery samples, reports percent level.
// Sample items: the result is registered in the cycle after acceptance. A report item with
//   samples runs the serial multiplier (SUM_W steps), then the serial divider for the mean
//   mV and, when high > low, a second divider pass for the percent.
// Throughput: one item at a time; samples 1 per cycle when output is taken at once.
// Reset (i_rst_n low, synchronous): accumulator and timestamp cleared, config to defaults.
// Depends on bla_pkg, bla_mul, bla_div.
`timescale 1ns / 1ps

module battery_level_averager_unit #(
    parameter int COUNT_BITS = bla_pkg::COUNT_BITS_DEF,
    parameter int ADC_BITS   = bla_pkg::ADC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [31:0] now_ms, [43:32] adc_code, [47:44] zero
    input  logic        s_axis_tuser,   // [0] kind: 0 sample, 1 report request

    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [13:0] percent_hundredths, [15:14] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] status

    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bla_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bla_pkg::CFG_W-1:0]      i_cfg_data
);

    // datapath widths
    localparam int SUM_W  = ADC_BITS + COUNT_BITS;
    localparam int PROD_W = SUM_W + bla_pkg::K_W;
    localparam int CD_W   = COUNT_BITS + ADC_BITS;
    localparam int DVS_W  = CD_W + bla_pkg::GAIN_FRAC;
    localparam int ITER_W = $clog2(PROD_W + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    // converter code bits in use
    localparam logic [bla_pkg::CODE_W-1:0] CODE_MASK =
        (ADC_BITS >= bla_pkg::CODE_W) ? {bla_pkg::CODE_W{1'b1}}
                                      : bla_pkg::CODE_W'((1 << ADC_BITS) - 1);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_DIV1  = 3'd2;
    localparam logic [2:0] S_SCALE = 3'd3;
    localparam logic [2:0] S_DIV2  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // config registers
    logic [bla_pkg::MV_CFG_W-1:0] r_high;
    logic [bla_pkg::MV_CFG_W-1:0] r_low;
    logic [bla_pkg::GAIN_W-1:0]   r_gain;
    logic [bla_pkg::INT_W-1:0]    r_interval;

    // accumulator
    logic [SUM_W-1:0]            r_sum;
    logic [COUNT_BITS-1:0]       r_count;
    logic [bla_pkg::NOW_W-1:0]   r_last;

    logic [2:0]                   r_state;
    logic [DVS_W-1:0]             r_dvs;
    logic [bla_pkg::MV_CFG_W-1:0] r_diff;
    logic                         r_window;
    logic [bla_pkg::PCT_W-1:0]    r_pct;

    // output register
    logic                         r_out_valid;
    logic [bla_pkg::STATUS_W-1:0] r_out_status;
    logic [bla_pkg::PCT_W-1:0]    r_out_pct;

    // input fields
    logic                         w_kind;
    logic [bla_pkg::NOW_W-1:0]    w_now;
    logic [bla_pkg::CODE_W-1:0]   w_code;

    logic                         w_out_free;
    logic                         w_accept;
    logic [bla_pkg::NOW_W-1:0]    w_elapsed;
    logic                         w_take;
    logic [bla_pkg::K_W-1:0]      w_k;
    logic [CD_W-1:0]              w_cnt_full;

    logic                         w_mul_start;
    logic                         w_mul_done;
    logic [PROD_W-1:0]            w_prod;

    logic                         w_div_start;
    logic [PROD_W-1:0]            w_div_dvd;
    logic [DVS_W-1:0]             w_div_dvs;
    logic [ITER_W-1:0]            w_div_iters;
    logic                         w_div_done;
    logic [PROD_W-1:0]            w_quo;

    logic [bla_pkg::MV_W-1:0]     w_mv;
    logic [bla_pkg::MV_CFG_W-1:0] w_mv_clamp;
    logic [bla_pkg::SCALE_W-1:0]  w_scaled;
    logic [bla_pkg::SCALE_W-1:0]  w_q2;
    logic                         w_load_out;
    logic [bla_pkg::STATUS_W-1:0] w_load_status;

    assign w_kind = s_axis_tuser;
    assign w_now  = s_axis_tdata[31:0];
    assign w_code = s_axis_tdata[43:32] & CODE_MASK;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // sample gate: interval elapsed (mod 2^32) and count not saturated
    assign w_elapsed = w_now - r_last;
    assign w_take    = (w_elapsed >= bla_pkg::NOW_W'(r_interval)) && (r_count != COUNT_MAX);

    // K = 3300 * gain, divisor = count * (2^ADC_BITS - 1) * 256
    assign w_k        = bla_pkg::K_W'(r_gain) * bla_pkg::K_W'(bla_pkg::MV_REF);
    assign w_cnt_full = {r_count, {ADC_BITS{1'b0}}} - CD_W'(r_count);

    // report with samples kicks off the serial multiply
    assign w_mul_start = w_accept && w_kind && (r_count != '0);

    bla_mul #(
        .A_W (SUM_W),
        .B_W (bla_pkg::K_W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (r_sum),
        .i_b     (w_k),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // percent scaling: (mv - low) * 10000, left-aligned for a SCALE_W-bit divide
    assign w_scaled = bla_pkg::SCALE_W'(r_diff) * bla_pkg::SCALE_W'(bla_pkg::FULL_PCT);

    // divider is shared: mean mV first, then the percent
    always_comb begin
        if (r_state == S_MUL) begin
            w_div_start = w_mul_done;
            w_div_dvd   = w_prod;
            w_div_dvs   = r_dvs;
            w_div_iters = ITER_W'(PROD_W);
        end else begin
            w_div_start = (r_state == S_SCALE) && r_window;
            w_div_dvd   = {w_scaled, {(PROD_W - bla_pkg::SCALE_W){1'b0}}};
            w_div_dvs   = DVS_W'(r_high - r_low);
            w_div_iters = ITER_W'(bla_pkg::SCALE_W);
        end
    end

    bla_div #(
        .N_W (PROD_W),
        .D_W (DVS_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_dvd   (w_div_dvd),
        .i_dvs   (w_div_dvs),
        .i_iters (w_div_iters),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // mean mV is known to fit MV_W bits; clamp into the window
    always_comb begin
        w_mv = w_quo[bla_pkg::MV_W-1:0];
        if (w_mv > bla_pkg::MV_W'(r_high)) begin
            w_mv_clamp = r_high;
        end else if (w_mv < bla_pkg::MV_W'(r_low)) begin
            w_mv_clamp = r_low;
        end else begin
            w_mv_clamp = w_mv[bla_pkg::MV_CFG_W-1:0];
        end
        w_q2 = w_quo[bla_pkg::SCALE_W-1:0];
    end

    // what goes into the output register this cycle
    always_comb begin
        w_load_out    = 1'b0;
        w_load_status = bla_pkg::ST_SAMPLING;
        if (w_accept) begin
            if (!w_kind) begin
                w_load_out    = 1'b1;
                w_load_status = bla_pkg::ST_SAMPLING;
            end else if (r_count == '0) begin
                w_load_out    = 1'b1;
                w_load_status = bla_pkg::ST_EMPTY;
            end
        end else if (r_state == S_DONE && w_out_free) begin
            w_load_out    = 1'b1;
            w_load_status = bla_pkg::ST_VALID;
        end
    end

    // control, config and accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_high      <= bla_pkg::MV_CFG_W'(4200);
            r_low       <= bla_pkg::MV_CFG_W'(3000);
            r_gain      <= bla_pkg::GAIN_W'(1178);
            r_interval  <= bla_pkg::INT_W'(5);
            r_sum       <= '0;
            r_count     <= '0;
            r_last      <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    bla_pkg::REG_HIGH:     r_high     <= i_cfg_data[bla_pkg::MV_CFG_W-1:0];
                    bla_pkg::REG_LOW:      r_low      <= i_cfg_data[bla_pkg::MV_CFG_W-1:0];
                    bla_pkg::REG_GAIN:     r_gain     <= i_cfg_data[bla_pkg::GAIN_W-1:0];
                    bla_pkg::REG_INTERVAL: r_interval <= i_cfg_data[bla_pkg::INT_W-1:0];
                    default: ;
                endcase
            end

            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (!w_kind) begin
                            if (w_take) begin
                                r_last  <= w_now;
                                r_sum   <= r_sum + SUM_W'(w_code);
                                r_count <= r_count + 1'b1;
                            end
                        end else begin
                            // report: sum and count are captured by the datapath
                            r_sum   <= '0;
                            r_count <= '0;
                            if (r_count != '0) begin
                                r_state <= S_MUL;
                            end
                        end
                    end
                end
                S_MUL: begin
                    if (w_mul_done) begin
                        r_state <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (w_div_done) begin
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_state <= r_window ? S_DIV2 : S_DONE;
                end
                S_DIV2: begin
                    if (w_div_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_mul_start) begin
            r_dvs <= {w_cnt_full, {bla_pkg::GAIN_FRAC{1'b0}}};
        end
        if (r_state == S_DIV1 && w_div_done) begin
            r_diff   <= w_mv_clamp - r_low;
            r_window <= r_high > r_low;
        end
        if (r_state == S_SCALE && !r_window) begin
            r_pct <= '0;
        end
        if (r_state == S_DIV2 && w_div_done) begin
            r_pct <= (w_q2 > bla_pkg::SCALE_W'(bla_pkg::FULL_PCT))
                   ? bla_pkg::PCT_W'(bla_pkg::FULL_PCT)
                   : w_q2[bla_pkg::PCT_W-1:0];
        end
        if (w_load_out) begin
            r_out_status <= w_load_status;
            r_out_pct    <= (w_load_status == bla_pkg::ST_VALID) ? r_pct : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_pct};
    assign m_axis_tuser  = r_out_status;

endmodule

FILE: verif/battery_level_checker.sv
// battery_level_checker: watches the item, result and register-write channels of the
// battery level averager, predicts each result and compares it with what comes out.
// Depends on bla_pkg.
`timescale 1ns / 1ps

module battery_level_checker
    import bla_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [47:0]          s_axis_tdata,
    input  logic                 s_axis_tuser,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [15:0]          m_axis_tdata,
    input  logic [1:0]           m_axis_tuser,
    input  logic                 i_cfg_valid,
    input  logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam longint unsigned COUNT_FULL = (64'd1 << COUNT_BITS_DEF) - 1;
    localparam longint unsigned ADC_FULL   = (64'd1 << ADC_BITS_DEF) - 1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PCT_W-1:0]    pct;
    } t_level;

    t_level due_levels[$];

    // mirror of the registers and the accumulator
    logic [MV_CFG_W-1:0] high_mv;
    logic [MV_CFG_W-1:0] low_mv;
    logic [GAIN_W-1:0]   gain;
    logic [INT_W-1:0]    interval;
    longint unsigned     sum;
    longint unsigned     count;
    logic [NOW_W-1:0]    last_ms;

    task automatic accumulate_or_report(input logic is_report, input logic [NOW_W-1:0] now,
                                        input logic [CODE_W-1:0] code);
        t_level           res;
        logic [NOW_W-1:0] elapsed;
        longint unsigned  k;
        longint unsigned  q;
        longint unsigned  r;
        longint unsigned  mv;
        longint unsigned  pct;
        res.status = ST_SAMPLING;
        res.pct    = '0;
        if (!is_report) begin
            elapsed = now - last_ms;   // wraps modulo 2^32
            if (elapsed >= interval && count < COUNT_FULL) begin
                last_ms = now;
                sum    += code;
                count  += 1;
            end
        end else if (count == 0) begin
            sum        = 0;
            res.status = ST_EMPTY;
        end else begin
            // mean code to mV without losing the remainder of sum / count
            k  = 64'(MV_REF) * gain;
            q  = sum / count;
            r  = sum % count;
            mv = (q * k + (r * k) / count) / (ADC_FULL * 256);
            sum        = 0;
            count      = 0;
            res.status = ST_VALID;
            if (high_mv > low_mv) begin
                if (mv > high_mv) mv = high_mv;
                if (mv < low_mv) mv = low_mv;
                pct = ((mv - low_mv) * FULL_PCT) / (high_mv - low_mv);
                if (pct > FULL_PCT) pct = FULL_PCT;
                res.pct = PCT_W'(pct);
            end
        end
        due_levels.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_level want;
        if (!i_rst_n) begin
            high_mv  = 14'd4200;
            low_mv   = 14'd3000;
            gain     = 16'd1178;
            interval = 8'd5;
            sum      = 0;
            count    = 0;
            last_ms  = '0;
            due_levels.delete();
            o_fail_count = 0;
            o_pending    = 0;
        end else begin
            // retire results before taking new items, so a result can never match
            // an item accepted at the same edge
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_levels.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("checker: result with nothing due, status %0d pct %0d",
                                 m_axis_tuser, m_axis_tdata[PCT_W-1:0]);
                end else begin
                    want = due_levels.pop_front();
                    if (m_axis_tuser !== want.status ||
                        m_axis_tdata[PCT_W-1:0] !== want.pct) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("checker: expected status %0d pct %0d, got %0d pct %0d",
                                     want.status, want.pct, m_axis_tuser,
                                     m_axis_tdata[PCT_W-1:0]);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                accumulate_or_report(s_axis_tuser, s_axis_tdata[NOW_W-1:0],
                                     s_axis_tdata[NOW_W+CODE_W-1:NOW_W]);
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_HIGH:     high_mv  = i_cfg_data[MV_CFG_W-1:0];
                    REG_LOW:      low_mv   = i_cfg_data[MV_CFG_W-1:0];
                    REG_GAIN:     gain     = i_cfg_data[GAIN_W-1:0];
                    REG_INTERVAL: interval = i_cfg_data[INT_W-1:0];
                    default: ;
                endcase
            end
            o_pending = due_levels.size();
        end
    end

endmodule

FILE: verif/battery_level_averager_unit_tb.sv
// battery_level_averager_unit_tb: stimulus and verdict for the battery level averager.
// Drives samples, reports and register writes; battery_level_checker does the checking.
// Depends on bla_pkg, battery_level_averager_unit, battery_level_checker.
`timescale 1ns / 1ps

module battery_level_averager_unit_tb;
    import bla_pkg::*;

    // watchdog limit, several times the length of the slowest legal run
    localparam int unsigned CYCLE_LIMIT  = 1_500_000;
    localparam int unsigned TOTAL_ITEMS  = 1050;
    localparam int unsigned RAND_PHASES  = 5;
    localparam int unsigned BURST_ITEMS  = 200;    // back-to-back full-scale samples
    localparam int unsigned TAIL_CYCLES  = 150;    // idle wait at the end, longer than a report takes at defaults

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [47:0]          s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [15:0]          m_axis_tdata;
    logic [1:0]           m_axis_tuser;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    int   fail_count;
    int   pending;
    bit   gaps_on = 1'b1;      // random idling on both channels
    int unsigned items_offered = 0;
    int unsigned cycle_count = 0;

    // stimulus copy of the registers, used to aim codes and timestamps
    int unsigned cur_high = 4200;
    int unsigned cur_low = 3000;
    int unsigned cur_gain = 1178;
    int unsigned cur_interval = 5;

    always #5 i_clk = ~i_clk;

    battery_level_averager_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    battery_level_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // result side: stalls about a third of the time unless idling is off
    always @(posedge i_clk) begin
        m_axis_tready <= gaps_on ? ($urandom_range(99) >= 33) : 1'b1;
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // Offer one item and hold it until accepted. tvalid is left high on return so
    // back-to-back items never lower and raise it in the same step.
    task automatic offer_item(input logic is_report, input logic [NOW_W-1:0] now,
                              input logic [CODE_W-1:0] code);
        while (gaps_on && $urandom_range(99) < 33) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= is_report;
        s_axis_tdata  <= {4'b0, code, now};
        do @(posedge i_clk); while (!s_axis_tready);
        items_offered++;
    endtask

    // Stop sending and wait until every predicted result has come out.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Writes all four registers once the block is idle. Unused upper data bits get
    // random values; the block must drop them.
    task automatic set_window(input int unsigned high, input int unsigned low,
                              input int unsigned gain, input int unsigned interval);
        settle();
        cur_high     = high;
        cur_low      = low;
        cur_gain     = gain;
        cur_interval = interval;
        write_reg(REG_HIGH, {2'($urandom_range(3)), 14'(high)});
        write_reg(REG_LOW, {2'($urandom_range(3)), 14'(low)});
        write_reg(REG_GAIN, 16'(gain));
        write_reg(REG_INTERVAL, {8'($urandom_range(255)), 8'(interval)});
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned      run_len;
        int unsigned      span;
        int unsigned      hi;
        int unsigned      lo;
        int unsigned      rand_base;
        longint unsigned  aim;
        logic [CODE_W-1:0] base;
        logic [CODE_W-1:0] code;
        logic [NOW_W-1:0]  clk_ms;
        logic [NOW_W-1:0]  now;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed, reset settings (window 3000..4200 mV, interval 5 ms) ----
        offer_item(1'b1, 32'd0, 12'd0);           // report before any sample: empty
        offer_item(1'b0, 32'd0, 12'd0);           // 0 ms since reset timestamp: dropped
        offer_item(1'b0, 32'd5, 12'hFFF);         // exactly the interval: taken
        offer_item(1'b0, 32'd9, 12'hFFF);         // too soon: dropped
        offer_item(1'b0, 32'd10, 12'd0);          // taken, mean has a remainder
        offer_item(1'b1, 32'd10, 12'd0);
        offer_item(1'b0, 32'hFFFF_FFFE, 12'd1000);
        offer_item(1'b0, 32'd3, 12'd1000);        // timestamp wrapped, 5 ms later
        offer_item(1'b1, 32'hFFFF_FFFF, 12'hFFF);
        offer_item(1'b1, 32'd0, 12'd0);           // accumulator was cleared: empty

        // widest window, largest gain, zero interval: every sample taken
        set_window(16383, 0, 65535, 0);
        offer_item(1'b0, 32'd3, 12'hFFF);
        offer_item(1'b0, 32'd3, 12'd0);
        offer_item(1'b1, 32'd3, 12'd0);
        offer_item(1'b0, 32'd0, 12'hFFF);
        offer_item(1'b1, 32'd0, 12'd0);           // far above the top: clamps to 100%

        // high equal to low, gain of one
        set_window(2000, 2000, 256, 0);
        offer_item(1'b0, 32'd1, 12'd2482);
        offer_item(1'b1, 32'd1, 12'd0);

        // high below low
        set_window(1000, 3000, 1178, 0);
        offer_item(1'b0, 32'd2, 12'd900);
        offer_item(1'b1, 32'd2, 12'd0);

        // gain below one halves the voltage
        set_window(3300, 0, 128, 0);
        offer_item(1'b0, 32'd7, 12'hFFF);
        offer_item(1'b1, 32'd7, 12'd0);

        // longest interval
        set_window(4200, 3000, 1178, 255);
        offer_item(1'b0, 32'd5000, 12'd1000);
        offer_item(1'b0, 32'd5254, 12'd1100);     // one ms short
        offer_item(1'b0, 32'd5255, 12'd1100);
        offer_item(1'b1, 32'd5255, 12'd0);

        // ---- full-scale samples back to back with no idling on either side ----
        set_window(4200, 3000, 1178, 0);
        gaps_on = 1'b0;
        for (int unsigned i = 0; i < BURST_ITEMS; i++)
            offer_item(1'b0, $urandom, 12'hFFF);
        offer_item(1'b1, $urandom, 12'($urandom));
        offer_item(1'b1, $urandom, 12'($urandom));
        gaps_on = 1'b1;

        // ---- random: runs of samples closed by a report, under several settings ----
        rand_base = items_offered;
        for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
            if ($urandom_range(4) == 0) begin
                hi = $urandom_range(0, 16383);
                lo = $urandom_range(0, 16383);
            end else begin
                lo = $urandom_range(2500, 3600);
                hi = lo + $urandom_range(0, 1500);
            end
            set_window(hi, lo, ($urandom_range(3) == 0) ? $urandom_range(256, 65535)
                                                         : $urandom_range(1000, 1400),
                       ($urandom_range(3) == 0) ? $urandom_range(0, 255)
                                                : $urandom_range(0, 20));
            clk_ms = $urandom;
            span   = (cur_high > cur_low) ? cur_high - cur_low : 0;
            while (items_offered <
                   rand_base + (ph + 1) * (TOTAL_ITEMS - rand_base) / RAND_PHASES) begin
                run_len = $urandom_range(1, 8);
                // half the runs aim inside the window so the percentage is not clamped
                if ($urandom_range(1)) begin
                    aim  = (64'(cur_low) + $urandom_range(0, span)) * 64'd4095 * 256 /
                           (64'd3300 * cur_gain);
                    base = (aim > 4095) ? 12'hFFF : aim[CODE_W-1:0];
                end else begin
                    base = 12'($urandom_range(0, 4095));
                end
                for (int unsigned i = 0; i < run_len; i++) begin
                    if ($urandom_range(9) == 0) begin
                        now = $urandom;                    // stray timestamp
                    end else begin
                        clk_ms += $urandom_range(0, 2 * cur_interval + 1);
                        now = clk_ms;
                    end
                    case ($urandom_range(15))
                        0:       code = 12'd0;
                        1:       code = 12'hFFF;
                        2:       code = 12'($urandom);
                        default: code = base ^ 12'($urandom_range(0, 63));
                    endcase
                    offer_item(1'b0, now, code);
                end
                // most runs end in a report; some merge into the next run
                if ($urandom_range(9) != 0)
                    offer_item(1'b1, $urandom, 12'($urandom));
                if ($urandom_range(9) == 0)
                    offer_item(1'b1, $urandom, 12'($urandom));
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
